FILE: src/hbts_pkg.sv
// ----------------------------------------------------------------------------
// hbts_pkg
// shared types and constants of the half-bit timing statistics unit
// ----------------------------------------------------------------------------
package hbts_pkg;

    localparam int MODE_W    = 2;
    localparam int LEN_W     = 16;
    localparam int CNT_W     = 32;
    localparam int MINLEN_W  = 10;
    localparam int RADDR_W   = 9;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [LEN_W-1:0]    MIN_RESET        = 16'hFFFF;
    localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = 10'd45;

    // item modes
    typedef enum logic [MODE_W-1:0] {
        MODE_RECORD = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    // register index on the configuration port
    localparam logic [0:0] REG_MIN_LENGTH = 1'b0;

    // scalar read map
    localparam logic [RADDR_W-1:0] ADDR_TOTAL      = 9'd0;
    localparam logic [RADDR_W-1:0] ADDR_ZERO_CNT   = 9'd1;
    localparam logic [RADDR_W-1:0] ADDR_ONE_CNT    = 9'd2;
    localparam logic [RADDR_W-1:0] ADDR_ZERO_MIN   = 9'd3;
    localparam logic [RADDR_W-1:0] ADDR_ZERO_MAX   = 9'd4;
    localparam logic [RADDR_W-1:0] ADDR_ZERO_SUM   = 9'd5;
    localparam logic [RADDR_W-1:0] ADDR_ZERO_DELTA = 9'd6;
    localparam logic [RADDR_W-1:0] ADDR_ONE_MIN    = 9'd7;
    localparam logic [RADDR_W-1:0] ADDR_ONE_MAX    = 9'd8;
    localparam logic [RADDR_W-1:0] ADDR_ONE_SUM    = 9'd9;
    localparam logic [RADDR_W-1:0] ADDR_ONE_DELTA  = 9'd10;

    // command from the front end to the histogram memory
    typedef struct packed {
        logic issue;  // read the entry at the given index
        logic inc;    // write back the entry plus one on the next cycle
        logic clear;  // start a clearing sweep
    } t_hist_cmd;

endpackage

FILE: src/hbts_in_if.sv
// ----------------------------------------------------------------------------
// hbts_in_if
// input item channel: valid/ready handshake with the item fields
// ----------------------------------------------------------------------------
interface hbts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        second_half;
    logic        bit_value;
    logic [15:0] half_bit_length;
    logic [15:0] bit_delta;
    logic [8:0]  read_address;

    modport source (
        output valid, mode, second_half, bit_value, half_bit_length, bit_delta,
               read_address,
        input  ready
    );
    modport sink (
        input  valid, mode, second_half, bit_value, half_bit_length, bit_delta,
               read_address,
        output ready
    );
endinterface

FILE: src/hbts_out_if.sv
// ----------------------------------------------------------------------------
// hbts_out_if
// result item channel: valid/ready handshake with the read word
// ----------------------------------------------------------------------------
interface hbts_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );
    modport sink (
        input  valid, read_data,
        output ready
    );
endinterface

FILE: src/hbts_hist.sv
// ----------------------------------------------------------------------------
// hbts_hist
// histogram memory with read-modify-write, forwarding and clearing sweep
// ----------------------------------------------------------------------------
module hbts_hist #(
    parameter int DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hbts_pkg::t_hist_cmd       i_cmd,
    input  logic [$clog2(DEPTH)-1:0]  i_idx,
    output logic [31:0]               o_rd_data,
    output logic                      o_busy
);
    import hbts_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [CNT_W-1:0] r_mem [DEPTH];

    logic [CNT_W-1:0] r_q;
    logic [CNT_W-1:0] r_fwd_data;
    logic             r_fwd_hit;
    logic             r_s1_inc;
    logic [AW-1:0]    r_s1_idx;
    logic             r_clr_active;
    logic [AW-1:0]    r_clr_idx;

    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] wr_data;
    logic             hit;

    // entry value as of the last issued read, newest write forwarded
    assign cur     = r_fwd_hit ? r_fwd_data : r_q;
    assign wr_data = cur + CNT_W'(1);
    assign hit     = r_s1_inc && (r_s1_idx == i_idx);

    assign o_rd_data = cur;
    assign o_busy    = r_clr_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_inc     <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else begin
            r_s1_inc <= i_cmd.issue && i_cmd.inc;
            if (i_cmd.clear) begin
                r_clr_active <= 1'b1;
                r_clr_idx    <= '0;
            end else if (r_clr_active) begin
                if (r_clr_idx == AW'(DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
                r_clr_idx <= r_clr_idx + AW'(1);
            end
        end
    end

    // payload and forwarding registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_idx   <= i_idx;
            r_fwd_hit  <= hit;
            r_fwd_data <= wr_data;
        end
    end

    // memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_q <= r_mem[i_idx];
        end
        if (r_clr_active) begin
            r_mem[r_clr_idx] <= '0;
        end else if (r_s1_inc) begin
            r_mem[r_s1_idx] <= wr_data;
        end
    end

endmodule

FILE: src/half_bit_timing_statistics_unit.sv
// ----------------------------------------------------------------------------
// half_bit_timing_statistics_unit
// timing statistics over measured half-bits: counts, min/max, sums, deltas
// and a length histogram held in a synchronous memory
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------
//  i_in      | in  | valid/ready        | mode, second_half, bit_value,
//            |     |                    | half_bit_length, bit_delta, read_address
//  o_out     | out | valid/ready        | read_data (read items only)
//  apb       | in  | psel/penable/pready| min_length at address 0
//
//  one item per cycle while i_in.ready is high; a read item's word passes
//  from the read stage into the output register, which drives o_out.valid
//  the histogram is a single-port-read/single-port-write memory; a record
//  item reads its bin when accepted and writes it back in the next cycle,
//  with the pending write forwarded to a following access of the same bin
//  after reset and after a clear item the memory is swept, one entry a cycle,
//  all 2*BINS entries (256 at the default), with i_in.ready low throughout
//  i_in.ready drops only while a read result is held back by o_out.ready low
//  and the output register is full, or during the sweep
//
// ----------------------------------------------------------------------------
module half_bit_timing_statistics_unit #(
    parameter int BINS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hbts_in_if.sink                       i_in,
    hbts_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hbts_pkg::PADDR_W-1:0]  paddr,
    input  logic [hbts_pkg::PDATA_W-1:0]  pwdata,
    output logic [hbts_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import hbts_pkg::*;

    localparam int DEPTH = 2 * BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int IXW   = (AW > 8) ? AW : 8;

    // configuration
    logic [MINLEN_W-1:0] r_min_length;

    // scalar statistics
    logic [CNT_W-1:0] r_total_count;
    logic [CNT_W-1:0] r_zero_count;
    logic [CNT_W-1:0] r_one_count;
    logic [LEN_W-1:0] r_zero_min;
    logic [LEN_W-1:0] r_zero_max;
    logic [CNT_W-1:0] r_zero_sum;
    logic [LEN_W-1:0] r_zero_max_delta;
    logic [LEN_W-1:0] r_one_min;
    logic [LEN_W-1:0] r_one_max;
    logic [CNT_W-1:0] r_one_sum;
    logic [LEN_W-1:0] r_one_max_delta;

    // read stage and output register
    logic             r_s1_rd;
    logic             r_s1_hist;
    logic [CNT_W-1:0] r_s1_data;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_data;

    logic             accept;
    logic             is_rec;
    logic             is_read;
    logic             is_clear;
    logic             s1_move;
    logic             s1_stall;
    logic             hist_busy;
    logic [CNT_W-1:0] hist_rd_data;
    t_hist_cmd        hist_cmd;
    logic [AW-1:0]    hist_idx;

    logic [LEN_W:0]   diff;
    logic [LEN_W:0]   hi_len;
    logic             below;
    logic             above;
    logic [BW-1:0]    bin;
    logic [AW-1:0]    rec_idx;
    logic [IXW-1:0]   rd_wide;
    logic [AW-1:0]    rd_idx;
    logic             rd_hist;
    logic [CNT_W-1:0] scalar_word;
    logic [LEN_W-1:0] len;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_LENGTH) ? PDATA_W'(r_min_length) : '0;

    // ---------------- handshake ----------------
    assign s1_move  = r_s1_rd && (!r_out_valid || o_out.ready);
    assign s1_stall = r_s1_rd && !s1_move;
    assign i_in.ready = !hist_busy && !s1_stall;
    assign accept   = i_in.valid && i_in.ready;

    assign is_rec   = accept && (i_in.mode == MODE_RECORD);
    assign is_read  = accept && (i_in.mode == MODE_READ);
    assign is_clear = accept && (i_in.mode == MODE_CLEAR);
    assign len      = i_in.half_bit_length;

    // ---------------- histogram bin ----------------
    // clamp to min_length .. min_length+BINS-1, bin is offset from min_length
    assign diff   = {1'b0, len} - (LEN_W+1)'(r_min_length);
    assign hi_len = (LEN_W+1)'(r_min_length) + (LEN_W+1)'(BINS - 1);
    assign below  = len < LEN_W'(r_min_length);
    assign above  = {1'b0, len} > hi_len;

    always_comb begin
        priority if (below) begin
            bin = '0;
        end else if (above) begin
            bin = BW'(BINS - 1);
        end else begin
            bin = diff[BW-1:0];
        end
    end

    assign rec_idx = i_in.second_half ? (AW'(BINS) + AW'(bin)) : AW'(bin);

    // histogram read address: upper half of the map, entry below 2*BINS
    assign rd_wide = IXW'(i_in.read_address[7:0]);
    assign rd_idx  = rd_wide[AW-1:0];
    assign rd_hist = i_in.read_address[8] && (32'(i_in.read_address[7:0]) < 32'(DEPTH));

    assign hist_idx       = is_rec ? rec_idx : rd_idx;
    assign hist_cmd.issue = is_rec || (is_read && rd_hist);
    assign hist_cmd.inc   = is_rec;
    assign hist_cmd.clear = is_clear;

    hbts_hist #(
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (hist_cmd),
        .i_idx     (hist_idx),
        .o_rd_data (hist_rd_data),
        .o_busy    (hist_busy)
    );

    // ---------------- scalar read map ----------------
    always_comb begin
        unique case (i_in.read_address)
            ADDR_TOTAL:      scalar_word = r_total_count;
            ADDR_ZERO_CNT:   scalar_word = r_zero_count;
            ADDR_ONE_CNT:    scalar_word = r_one_count;
            ADDR_ZERO_MIN:   scalar_word = CNT_W'(r_zero_min);
            ADDR_ZERO_MAX:   scalar_word = CNT_W'(r_zero_max);
            ADDR_ZERO_SUM:   scalar_word = r_zero_sum;
            ADDR_ZERO_DELTA: scalar_word = CNT_W'(r_zero_max_delta);
            ADDR_ONE_MIN:    scalar_word = CNT_W'(r_one_min);
            ADDR_ONE_MAX:    scalar_word = CNT_W'(r_one_max);
            ADDR_ONE_SUM:    scalar_word = r_one_sum;
            ADDR_ONE_DELTA:  scalar_word = CNT_W'(r_one_max_delta);
            default:         scalar_word = '0;
        endcase
    end

    // ---------------- configuration register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_MIN_LENGTH)) begin
            r_min_length <= pwdata[MINLEN_W-1:0];
        end
    end

    // ---------------- scalar statistics ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || is_clear) begin
            r_total_count    <= '0;
            r_zero_count     <= '0;
            r_one_count      <= '0;
            r_zero_min       <= MIN_RESET;
            r_zero_max       <= '0;
            r_zero_sum       <= '0;
            r_zero_max_delta <= '0;
            r_one_min        <= MIN_RESET;
            r_one_max        <= '0;
            r_one_sum        <= '0;
            r_one_max_delta  <= '0;
        end else if (is_rec) begin
            r_total_count <= r_total_count + CNT_W'(1);
            if (!i_in.bit_value) begin
                r_zero_count <= r_zero_count + CNT_W'(1);
                r_zero_sum   <= r_zero_sum + CNT_W'(len);
                if (len > r_zero_max) begin
                    r_zero_max <= len;
                end
                if (len < r_zero_min) begin
                    r_zero_min <= len;
                end
                if (i_in.second_half && (i_in.bit_delta > r_zero_max_delta)) begin
                    r_zero_max_delta <= i_in.bit_delta;
                end
            end else begin
                r_one_count <= r_one_count + CNT_W'(1);
                r_one_sum   <= r_one_sum + CNT_W'(len);
                if (len > r_one_max) begin
                    r_one_max <= len;
                end
                if (len < r_one_min) begin
                    r_one_min <= len;
                end
                if (i_in.second_half && (i_in.bit_delta > r_one_max_delta)) begin
                    r_one_max_delta <= i_in.bit_delta;
                end
            end
        end
    end

    // ---------------- read stage and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_rd     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_rd <= is_read;
            end else if (s1_move) begin
                r_s1_rd <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_s1_hist <= rd_hist;
            r_s1_data <= scalar_word;
        end
        if (s1_move) begin
            // histogram words come from the memory's read or forwarding register, loaded at the read
            r_out_data <= r_s1_hist ? hist_rd_data : r_s1_data;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;

endmodule
